[rtl/hlbc_pkg.sv]
// Shared types and constants for the hashed LRU block cache directory.
// No dependencies; every other file imports this package.
package hlbc_pkg;

  localparam int BUFFER_COUNT_DEF = 32;
  localparam int BUCKET_COUNT_DEF = 13;
  localparam int ACTION_W = 2;
  localparam int DEVICE_W = 8;
  localparam int BLOCK_W = 32;
  localparam int INDEX_W = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_GET     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_PIN     = 2'd2,
    ACT_UNPIN   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_COUNT_ERR = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    C_NONE, C_LOAD, C_MOD_STEP, C_COUNT, C_MATCH_LOAD, C_WALK_OLDER, C_HIT,
    C_FREE_LOAD, C_WALK_NEWER, C_NEXT_BUCKET, C_NO_FREE, C_DETACH, C_PUSH,
    C_PUSH_FIN, C_EMIT
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ROUTE, S_COUNT, S_MOD, S_MATCH_LOAD, S_MATCH, S_HIT, S_FREE_LOAD,
    S_FREE, S_DETACH, S_PUSH, S_PUSH_FIN, S_EMIT
  } state_t;

  typedef struct packed {
    logic is_get;
    logic idx_ok;
    logic mod_last;
    logic cur_null;
    logic steps_done;
    logic tag_match;
    logic cnt_zero;
    logic release_move;
    logic last_bucket;
  } dp_status_t;

endpackage

[rtl/hlbc_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on hlbc_pkg for field widths.
interface hlbc_req_if import hlbc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [DEVICE_W-1:0] device;
  logic [BLOCK_W-1:0]  block_number;
  logic [INDEX_W-1:0]  buffer_index;
  modport source (output valid, action, device, block_number, buffer_index, input ready);
  modport sink (input valid, action, device, block_number, buffer_index, output ready);
endinterface

interface hlbc_rsp_if import hlbc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  granted_buffer;
  logic                was_hit;
  logic                needs_fill;
  modport source (output valid, status, granted_buffer, was_hit, needs_fill, input ready);
  modport sink (input valid, status, granted_buffer, was_hit, needs_fill, output ready);
endinterface

[rtl/hlbc_dp.sv]
// Datapath: tag, count and link stores, the bucket modulo unit, list walk
// registers and the response register. Depends on hlbc_pkg.
module hlbc_dp import hlbc_pkg::*; #(
  parameter int BUFFER_COUNT = BUFFER_COUNT_DEF,
  parameter int BUCKET_COUNT = BUCKET_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output dp_status_t          sts,
  input  logic [ACTION_W-1:0] action,
  input  logic [DEVICE_W-1:0] device,
  input  logic [BLOCK_W-1:0]  block_number,
  input  logic [INDEX_W-1:0]  buffer_index,
  output logic [STATUS_W-1:0] status,
  output logic [INDEX_W-1:0]  granted_buffer,
  output logic                was_hit,
  output logic                needs_fill
);

  localparam int IW = $clog2(BUFFER_COUNT);
  localparam int LW = $clog2(BUFFER_COUNT + 1);
  localparam int KW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int RW = $clog2(2 * BUCKET_COUNT);
  localparam logic [LW-1:0] LINK_NULL = LW'(BUFFER_COUNT);
  localparam logic [KW-1:0] LAST_BUCKET = KW'(BUCKET_COUNT - 1);
  localparam logic [RW-1:0] MODULUS = RW'(BUCKET_COUNT);

  // byte value mod bucket count
  function automatic logic [256*RW-1:0] byte_mod_table();
    logic [256*RW-1:0] tbl;
    tbl = '0;
    for (int i = 0; i < 256; i++) tbl[i*RW +: RW] = RW'(i % BUCKET_COUNT);
    return tbl;
  endfunction

  // (remainder * 256) mod bucket count
  function automatic logic [(2**RW)*RW-1:0] shift_mod_table();
    logic [(2**RW)*RW-1:0] tbl;
    tbl = '0;
    for (int i = 0; i < 2**RW; i++) tbl[i*RW +: RW] = RW'((i * 256) % BUCKET_COUNT);
    return tbl;
  endfunction

  localparam logic [256*RW-1:0]      BYTE_MOD  = byte_mod_table();
  localparam logic [(2**RW)*RW-1:0] SHIFT_MOD = shift_mod_table();

  logic [DEVICE_W-1:0] tag_device [BUFFER_COUNT];
  logic [BLOCK_W-1:0]  tag_block [BUFFER_COUNT];
  logic                contents_valid [BUFFER_COUNT];
  logic [COUNT_W-1:0]  ref_count [BUFFER_COUNT];
  logic [LW-1:0]       older [BUFFER_COUNT];
  logic [LW-1:0]       newer [BUFFER_COUNT];
  logic [LW-1:0]       bucket_newest [BUCKET_COUNT];
  logic [LW-1:0]       bucket_oldest [BUCKET_COUNT];

  action_t             act;
  logic                idx_ok;
  logic [DEVICE_W-1:0] dev;
  logic [BLOCK_W-1:0]  blk;
  logic [BLOCK_W-1:0]  modop;
  logic [1:0]          bitcnt;
  logic [RW-1:0]       rem;
  logic [LW-1:0]       cur;
  logic [LW-1:0]       steps;
  logic [KW-1:0]       from;
  logic [KW-1:0]       j;
  status_t             res_status;
  logic [INDEX_W-1:0]  res_grant;
  logic                res_hit;
  logic                res_fill;

  logic [IW-1:0]       bidx;
  logic [KW-1:0]       home;
  logic [LW-1:0]       lo, ln, hh;
  logic [COUNT_W-1:0]  c_cnt;
  logic [7:0]          mod_byte;
  logic [RW-1:0]       msum;
  logic [RW-1:0]       rem_next;

  assign bidx  = cur[IW-1:0];
  assign home  = rem[KW-1:0];
  assign lo    = older[bidx];
  assign ln    = newer[bidx];
  assign hh    = bucket_newest[home];
  assign c_cnt = ref_count[bidx];

  // one byte a cycle, most significant first; fold the remainder through the tables
  assign mod_byte = modop[BLOCK_W-1 -: 8];
  assign msum     = SHIFT_MOD[rem*RW +: RW] + BYTE_MOD[mod_byte*RW +: RW];
  assign rem_next = (msum >= MODULUS) ? msum - MODULUS : msum;

  always_comb begin
    sts.is_get       = (act == ACT_GET);
    sts.idx_ok       = idx_ok;
    sts.mod_last     = (bitcnt == 2'd3);
    sts.cur_null     = (cur >= LINK_NULL);
    sts.steps_done   = (steps == LINK_NULL);
    sts.tag_match    = (tag_device[bidx] == dev) && (tag_block[bidx] == blk);
    sts.cnt_zero     = (c_cnt == '0);
    sts.release_move = (act == ACT_RELEASE) && (c_cnt == COUNT_W'(1));
    sts.last_bucket  = (j == LAST_BUCKET);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        tag_device[i]     <= '0;
        tag_block[i]      <= '0;
        contents_valid[i] <= 1'b0;
        ref_count[i]      <= '0;
        older[i]          <= (i == 0) ? LINK_NULL : LW'(i - 1);
        newer[i]          <= (i == BUFFER_COUNT - 1) ? LINK_NULL : LW'(i + 1);
      end
      for (int k = 0; k < BUCKET_COUNT; k++) begin
        bucket_newest[k] <= (k == 0) ? LW'(BUFFER_COUNT - 1) : LINK_NULL;
        bucket_oldest[k] <= (k == 0) ? '0 : LINK_NULL;
      end
    end else begin
      case (cmd)
        C_LOAD: begin
          act        <= action_t'(action);
          idx_ok     <= (int'(buffer_index) < BUFFER_COUNT);
          dev        <= device;
          blk        <= block_number;
          modop      <= block_number;
          rem        <= '0;
          bitcnt     <= '0;
          cur        <= LW'(buffer_index);
          res_status <= ST_OK;
          res_grant  <= '0;
          res_hit    <= 1'b0;
          res_fill   <= 1'b0;
        end
        C_MOD_STEP: begin
          rem    <= rem_next;
          modop  <= modop << 8;
          bitcnt <= bitcnt + 2'd1;
          from   <= rem_next[KW-1:0];
          j      <= '0;
        end
        C_COUNT: begin
          modop  <= tag_block[bidx];
          rem    <= '0;
          bitcnt <= '0;
          if (act == ACT_PIN) begin
            if (c_cnt == COUNT_MAX) res_status <= ST_COUNT_ERR;
            else ref_count[bidx] <= c_cnt + 1'b1;
          end else begin
            if (c_cnt == '0) res_status <= ST_COUNT_ERR;
            else ref_count[bidx] <= c_cnt - 1'b1;
          end
        end
        C_MATCH_LOAD: begin
          cur   <= hh;
          steps <= '0;
        end
        C_WALK_OLDER: begin
          cur   <= lo;
          steps <= steps + 1'b1;
        end
        C_HIT: begin
          if (c_cnt == COUNT_MAX) begin
            res_status <= ST_COUNT_ERR;
          end else begin
            ref_count[bidx]      <= c_cnt + 1'b1;
            contents_valid[bidx] <= 1'b1;
            res_grant            <= INDEX_W'(cur);
            res_hit              <= 1'b1;
            res_fill             <= !contents_valid[bidx];
          end
        end
        C_FREE_LOAD: begin
          cur   <= bucket_oldest[from];
          steps <= '0;
        end
        C_WALK_NEWER: begin
          cur   <= ln;
          steps <= steps + 1'b1;
        end
        C_NEXT_BUCKET: begin
          j    <= j + 1'b1;
          from <= (from == LAST_BUCKET) ? '0 : from + 1'b1;
        end
        C_NO_FREE: res_status <= ST_NO_FREE;
        C_DETACH: begin
          // unlink cur from bucket from
          if (ln < LINK_NULL) older[ln[IW-1:0]] <= lo;
          else bucket_newest[from] <= lo;
          if (lo < LINK_NULL) newer[lo[IW-1:0]] <= ln;
          else bucket_oldest[from] <= ln;
        end
        C_PUSH: begin
          older[bidx] <= hh;
          if (hh < LINK_NULL) newer[hh[IW-1:0]] <= cur;
          else bucket_oldest[home] <= cur;
          bucket_newest[home] <= cur;
        end
        C_PUSH_FIN: begin
          newer[bidx] <= LINK_NULL;
          if (act == ACT_GET) begin
            tag_device[bidx]     <= dev;
            tag_block[bidx]      <= blk;
            ref_count[bidx]      <= COUNT_W'(1);
            contents_valid[bidx] <= 1'b1;
            res_grant            <= INDEX_W'(cur);
            res_fill             <= 1'b1;
          end
        end
        C_EMIT: begin
          status         <= res_status;
          granted_buffer <= res_grant;
          was_hit        <= res_hit;
          needs_fill     <= res_fill;
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/hlbc_ctrl.sv]
// Sequencer for the directory: walks lists, drives datapath commands and
// owns the request and response handshakes. Depends on hlbc_pkg.
module hlbc_ctrl import hlbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t sts,
  output cmd_t       cmd
);

  state_t state, state_next;
  logic   emit_fire;

  assign emit_fire = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (in_valid) state_next = S_ROUTE;
      S_ROUTE: begin
        if (sts.is_get) state_next = S_MOD;
        else if (sts.idx_ok) state_next = S_COUNT;
        else state_next = S_EMIT;
      end
      S_COUNT:      state_next = sts.release_move ? S_MOD : S_EMIT;
      S_MOD: begin
        if (sts.mod_last) state_next = sts.is_get ? S_MATCH_LOAD : S_DETACH;
      end
      S_MATCH_LOAD: state_next = S_MATCH;
      S_MATCH: begin
        if (sts.cur_null || sts.steps_done) state_next = S_FREE_LOAD;
        else if (sts.tag_match) state_next = S_HIT;
      end
      S_HIT:        state_next = S_EMIT;
      S_FREE_LOAD:  state_next = S_FREE;
      S_FREE: begin
        if (sts.cur_null || sts.steps_done) begin
          state_next = sts.last_bucket ? S_EMIT : S_FREE_LOAD;
        end else if (sts.cnt_zero) begin
          state_next = S_DETACH;
        end
      end
      S_DETACH:     state_next = S_PUSH;
      S_PUSH:       state_next = S_PUSH_FIN;
      S_PUSH_FIN:   state_next = S_EMIT;
      S_EMIT:       if (emit_fire) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = C_NONE;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = C_LOAD;
      end
      S_COUNT:      cmd = C_COUNT;
      S_MOD:        cmd = C_MOD_STEP;
      S_MATCH_LOAD: cmd = C_MATCH_LOAD;
      S_MATCH: begin
        if (!(sts.cur_null || sts.steps_done) && !sts.tag_match) cmd = C_WALK_OLDER;
      end
      S_HIT:        cmd = C_HIT;
      S_FREE_LOAD:  cmd = C_FREE_LOAD;
      S_FREE: begin
        if (sts.cur_null || sts.steps_done) begin
          cmd = sts.last_bucket ? C_NO_FREE : C_NEXT_BUCKET;
        end else if (!sts.cnt_zero) begin
          cmd = C_WALK_NEWER;
        end
      end
      S_DETACH:     cmd = C_DETACH;
      S_PUSH:       cmd = C_PUSH;
      S_PUSH_FIN:   cmd = C_PUSH_FIN;
      S_EMIT:       if (emit_fire) cmd = C_EMIT;
      default:      cmd = C_NONE;
    endcase
  end

`ifndef ASSERT_OFF
  a_rsp_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("response raised outside emit");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state != S_IDLE)
    else $error("request beat accepted but sequencer stayed idle");
  a_emit_completes: assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> out_valid && state == S_IDLE)
    else $error("emit did not present a response");
`endif

endmodule

[rtl/hashed_lru_block_cache_directory.sv]
// Get: the bucket modulo and setup, then a walk of the home list from newest to
// oldest for a matching tag and, on a miss, a search of the buckets from the home
// bucket on, each from its oldest entry, for a free buffer.
// One request at a time; a request is taken only while the sequencer is idle.
// Synchronous reset puts every buffer in bucket zero at once, no clear pass.
module hashed_lru_block_cache_directory import hlbc_pkg::*; #(
  parameter int BUFFER_COUNT = BUFFER_COUNT_DEF,
  parameter int BUCKET_COUNT = BUCKET_COUNT_DEF
) (
  input logic       clk,
  input logic       rst,
  hlbc_req_if.sink  req,
  hlbc_rsp_if.source rsp
);

  cmd_t       cmd;
  dp_status_t sts;

  hlbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hlbc_dp #(
    .BUFFER_COUNT (BUFFER_COUNT),
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .action         (req.action),
    .device         (req.device),
    .block_number   (req.block_number),
    .buffer_index   (req.buffer_index),
    .status         (rsp.status),
    .granted_buffer (rsp.granted_buffer),
    .was_hit        (rsp.was_hit),
    .needs_fill     (rsp.needs_fill)
  );

endmodule

[bench/hlbc_tb_if.sv]
// Testbench note: the channel interfaces come from rtl/hlbc_if.sv (hlbc_req_if, hlbc_rsp_if).
// This file holds only the directory-state predictor used by the bench; depends on hlbc_pkg.
package hlbc_tb_pkg;
  import hlbc_pkg::*;

  localparam int NBUF = BUFFER_COUNT_DEF;
  localparam int NBKT = BUCKET_COUNT_DEF;
  localparam logic [5:0] NIL = 6'h3f;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] granted;
    logic               hit;
    logic               fill;
  } reply_t;

  class cache_scoreboard;
    logic [7:0]  dev_tag[NBUF];
    logic [31:0] blk_tag[NBUF];
    bit          valid_q[NBUF];
    logic [7:0]  refs[NBUF];
    logic [5:0]  older[NBUF];
    logic [5:0]  newer[NBUF];
    logic [5:0]  head[NBKT];
    logic [5:0]  tail[NBKT];
    reply_t      pending[$];
    int          errors;

    function new();
      errors = 0;
      for (int i = 0; i < NBUF; i++) begin
        dev_tag[i] = 0; blk_tag[i] = 0; valid_q[i] = 0; refs[i] = 0;
        older[i] = NIL; newer[i] = NIL;
      end
      for (int k = 0; k < NBKT; k++) begin
        head[k] = NIL; tail[k] = NIL;
      end
      for (int i = 0; i < NBUF; i++) to_head(i, 0);
    endfunction

    function void unlink(int b, int k);
      logic [5:0] o, n;
      o = older[b]; n = newer[b];
      if (n != NIL) older[n] = o; else head[k] = o;
      if (o != NIL) newer[o] = n; else tail[k] = n;
      older[b] = NIL; newer[b] = NIL;
    endfunction

    function void to_head(int b, int k);
      logic [5:0] h;
      h = head[k];
      older[b] = h; newer[b] = NIL;
      if (h != NIL) newer[h] = 6'(b); else tail[k] = 6'(b);
      head[k] = 6'(b);
    endfunction

    function int oldest_free(int k);
      logic [5:0] b;
      b = tail[k];
      for (int s = 0; s < NBUF && b != NIL; s++) begin
        if (refs[b] == 0) return int'(b);
        b = newer[b];
      end
      return -1;
    endfunction

    // Work out the reply for one request beat and queue it.
    function void note_request(action_t act, logic [7:0] dev, logic [31:0] blk,
                               logic [4:0] idx);
      reply_t r;
      int home, b, from;
      logic [5:0] p;
      r = '0;
      r.status = ST_OK;
      if (act == ACT_GET) begin
        home = int'(blk % NBKT);
        b = -1;
        p = head[home];
        for (int s = 0; s < NBUF && p != NIL; s++) begin
          if (dev_tag[p] == dev && blk_tag[p] == blk) begin
            b = int'(p); break;
          end
          p = older[p];
        end
        if (b >= 0) begin
          if (refs[b] == COUNT_MAX) r.status = ST_COUNT_ERR;
          else begin
            refs[b]++;
            r.granted = INDEX_W'(b); r.hit = 1; r.fill = !valid_q[b];
            valid_q[b] = 1;
          end
        end else begin
          from = home;
          b = oldest_free(home);
          for (int j = 1; b < 0 && j < NBKT; j++) begin
            from = (home + j) % NBKT;
            b = oldest_free(from);
          end
          if (b >= 0) begin
            unlink(b, from); to_head(b, home);
            dev_tag[b] = dev; blk_tag[b] = blk; refs[b] = 1; valid_q[b] = 1;
            r.granted = INDEX_W'(b); r.fill = 1;
          end else r.status = ST_NO_FREE;
        end
      end else if (idx < NBUF) begin
        if (act == ACT_PIN) begin
          if (refs[idx] == COUNT_MAX) r.status = ST_COUNT_ERR;
          else refs[idx]++;
        end else if (refs[idx] == 0) r.status = ST_COUNT_ERR;
        else begin
          refs[idx]--;
          if (act == ACT_RELEASE && refs[idx] == 0) begin
            unlink(int'(idx), int'(blk_tag[idx] % NBKT));
            to_head(int'(idx), int'(blk_tag[idx] % NBKT));
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_reply(logic [1:0] st, logic [4:0] gb, logic hit, logic fill);
      reply_t e;
      if (pending.size() == 0) begin
        $error("reply with nothing outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status expected %0d actual %0d", e.status, st); errors++;
      end
      if (gb !== e.granted) begin
        $error("granted_buffer expected %0d actual %0d", e.granted, gb); errors++;
      end
      if (hit !== e.hit) begin
        $error("was_hit expected %0d actual %0d", e.hit, hit); errors++;
      end
      if (fill !== e.fill) begin
        $error("needs_fill expected %0d actual %0d", e.fill, fill); errors++;
      end
    endfunction
  endclass
endpackage

[bench/tb_hashed_lru_block_cache_directory.sv]
// Testbench top: drives request beats, checks every reply against the predictor.
// Depends on hlbc_pkg, hlbc_if and hlbc_tb_pkg.
module tb_hashed_lru_block_cache_directory;
  import hlbc_pkg::*;
  import hlbc_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  int   src_idle = 0;
  int   snk_idle = 0;
  cache_scoreboard board;
  logic [31:0] recent_blk[8];
  logic [7:0]  recent_dev[8];
  int   held[$];

  hlbc_req_if req ();
  hlbc_rsp_if rsp ();

  hashed_lru_block_cache_directory u_top (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  initial forever #4 clk = ~clk;

  initial begin
    #20_000_000;
    $display("hashed_lru_block_cache_directory: mismatch");
    $finish;
  end

  // Receiver: random back-pressure, check each reply beat.
  always @(posedge clk) begin
    if (rst) rsp.ready <= 0;
    else begin
      if (rsp.valid && rsp.ready)
        board.check_reply(rsp.status, rsp.granted_buffer, rsp.was_hit, rsp.needs_fill);
      rsp.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // Drop valid only while idling, so each edge sees a single drive of it.
  task automatic send(action_t act, logic [7:0] dev, logic [31:0] blk, logic [4:0] idx);
    while ($urandom_range(99) < src_idle) begin
      req.valid <= 0;
      @(posedge clk);
    end
    req.valid <= 1;
    req.action <= act; req.device <= dev; req.block_number <= blk;
    req.buffer_index <= idx;
    do @(posedge clk); while (!req.ready);
    board.note_request(act, dev, blk, idx);
    if (act == ACT_GET && board.pending[$].status == ST_OK)
      held.push_back(int'(board.pending[$].granted));
  endtask

  task automatic random_beat();
    int sel, r;
    logic [31:0] blk;
    logic [7:0] dev;
    sel = $urandom_range(99);
    if (sel < 45) begin
      r = $urandom_range(7);
      if ($urandom_range(2) == 0) begin
        blk = $urandom; dev = 8'($urandom);
        if ($urandom_range(1)) blk = $urandom_range(40);
        recent_blk[r] = blk; recent_dev[r] = dev;
      end else begin
        blk = recent_blk[r]; dev = recent_dev[r];
      end
      send(ACT_GET, dev, blk, 0);
    end else if (sel < 85 && held.size() > 0) begin
      r = $urandom_range(held.size() - 1);
      send(($urandom_range(3) == 0) ? ACT_UNPIN : ACT_RELEASE, 8'($urandom), $urandom,
           5'(held[r]));
      held.delete(r);
    end else begin
      send(action_t'($urandom_range(3)), 8'($urandom), $urandom, 5'($urandom));
    end
  endtask

  initial begin
    board = new();
    req.valid = 0; req.action = ACT_GET; req.device = 0;
    req.block_number = 0; req.buffer_index = 0;
    for (int i = 0; i < 8; i++) begin
      recent_blk[i] = i; recent_dev[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: hit on invalid buffer, extremes, every action, errors.
    send(ACT_GET, 8'h00, 32'h0, 0);
    send(ACT_GET, 8'h00, 32'h0, 0);
    send(ACT_GET, 8'hff, 32'hffff_ffff, 0);
    send(ACT_RELEASE, 0, 0, 5'd31);
    send(ACT_UNPIN, 0, 0, 5'd30);
    send(ACT_PIN, 0, 0, 5'd30);
    send(ACT_UNPIN, 0, 0, 5'd30);
    send(ACT_RELEASE, 0, 0, 5'd31);
    for (int i = 0; i < 256; i++) send(ACT_PIN, 0, 0, 5'd7);
    send(ACT_GET, 8'h5a, 32'd14, 0);
    for (int i = 0; i < 256; i++) send(ACT_UNPIN, 0, 0, 5'd7);
    // Exhaust every buffer, then ask once more.
    for (int i = 0; i < 33; i++) send(ACT_GET, 8'h11, 32'd1000 + i, 0);
    for (int i = 0; i < 32; i++) send(ACT_RELEASE, 0, 0, 5'(i));
    for (int i = 0; i < 32; i++) send(ACT_RELEASE, 0, 0, 5'(i));
    held.delete();
    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 25 : (ph == 1) ? 86 : 0;
      snk_idle = (ph == 0) ? 86 : (ph == 1) ? 25 : 0;
      for (int n = 0; n < 210; n++) random_beat();
    end
    req.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("hashed_lru_block_cache_directory: match");
    else
      $display("hashed_lru_block_cache_directory: mismatch");
    $finish;
  end
endmodule

[filelist.f]
rtl/hlbc_pkg.sv
rtl/hlbc_if.sv
rtl/hlbc_dp.sv
rtl/hlbc_ctrl.sv
rtl/hashed_lru_block_cache_directory.sv
bench/hlbc_tb_if.sv
bench/tb_hashed_lru_block_cache_directory.sv
